// ----- design/ffc_pkg.sv -----
`default_nettype none
package ffc_pkg;

  localparam logic [2:0] OP_H2S  = 3'd0;
  localparam logic [2:0] OP_S2H  = 3'd1;
  localparam logic [2:0] OP_D2H  = 3'd2;
  localparam logic [2:0] OP_S2BF = 3'd3;
  localparam logic [2:0] OP_D2BF = 3'd4;

  localparam int unsigned OpW  = 3;
  localparam int unsigned SrcW = 64;
  localparam int unsigned ResW = 32;

endpackage
`default_nettype wire

// ----- design/ffc_narrow.sv -----
`default_nettype none
// Narrows a single or double encoding to a 16-bit format with round to nearest even.
// Significand widths: ssig 23 or 52, dsig 10 or 7.
module ffc_narrow (
  input  wire logic [63:0] operand_i,
  input  wire logic        src_dbl_i,
  input  wire logic        dst_bf_i,
  output logic      [15:0] result_o
);
  import ffc_pkg::*;

  logic        sign;
  logic [10:0] sexp;
  logic [52:0] sig;      // hidden one at bit 52, fraction left aligned
  logic        is_nan, is_inf_src;
  logic [12:0] dexp;     // signed result exponent (biased to destination)
  logic [63:0] mant;     // significand with hidden one at bit 63
  logic [6:0]  shift;
  logic [63:0] den;
  logic        sticky;
  logic [11:0] keep;
  logic [11:0] rnd;
  logic        guard, rest;
  logic [15:0] mag;
  logic [9:0]  payload;

  always_comb begin
    sign = 1'b0;
    sexp = '0;
    sig  = '0;
    if (src_dbl_i) begin
      sign = operand_i[63];
      sexp = operand_i[62:52];
      sig  = {1'b1, operand_i[51:0]};
    end else begin
      sign = operand_i[31];
      sexp = {3'b0, operand_i[30:23]};
      sig  = {1'b1, operand_i[22:0], 29'b0};
    end
    is_inf_src = src_dbl_i ? (sexp == 11'h7ff) : (sexp == 11'h0ff);
    is_nan     = is_inf_src && (sig[51:0] != '0);
    // Destination biased exponent: e - sbias + dbias.
    dexp = {2'b0, sexp} - (src_dbl_i ? 13'd1023 : 13'd127) + (dst_bf_i ? 13'd127 : 13'd15);

    mant = {sig, 11'b0};
    // Right shift so the result lands as a subnormal where dexp <= 0.
    if ($signed(dexp) >= 13'sd1) shift = '0;
    else if ($signed(dexp) < -13'sd62) shift = 7'd64;
    else shift = 7'(13'd1 - dexp);
    den    = (shift >= 7'd64) ? 64'd0 : (mant >> shift[5:0]);
    sticky = (shift >= 7'd64) ? 1'b1 : ((mant & ~(64'hffff_ffff_ffff_ffff << shift[5:0])) != 0);
    // Keep dsig+1 bits (hidden one plus fraction) from den's top.
    if (dst_bf_i) begin
      keep  = {4'b0, den[63:56]};
      guard = den[55];
      rest  = (den[54:0] != 0) | sticky;
    end else begin
      keep  = {1'b0, den[63:53]};
      guard = den[52];
      rest  = (den[51:0] != 0) | sticky;
    end
    rnd = keep + {11'b0, guard & (rest | keep[0])};

    payload = src_dbl_i ? operand_i[50:41] : operand_i[21:12];
    mag = '0;
    if (is_nan) begin
      mag = dst_bf_i ? {1'b0, 8'hff, 1'b1, payload[9:4]}
                     : {1'b0, 5'h1f, 1'b1, payload[9:1]};
    end else if (sexp == '0) begin
      mag = '0;
    end else if (dst_bf_i ? ($signed(dexp) >= 13'sd255) : ($signed(dexp) >= 13'sd31)) begin
      mag = dst_bf_i ? 16'h7f80 : 16'h7c00;
    end else if ($signed(dexp) >= 13'sd1) begin
      // Normal range: exponent plus rounded significand, carry rolls into exponent.
      mag = dst_bf_i ? 16'({dexp[7:0], 7'b0} + {4'b0, rnd} - 16'h0080)
                     : 16'({dexp[4:0], 10'b0} + {4'b0, rnd} - 16'h0400);
    end else begin
      mag = 16'(rnd);
    end
    result_o = {sign, mag[14:0]};
  end

endmodule
`default_nettype wire

// ----- design/float_format_converter.sv -----
`default_nettype none
// IEEE format converter. One item (op_i, operand_i) is taken in every cycle that
// start_i is high; busy_o is always low because nothing inside ever holds work
// back. valid_o and the converted value on result_o appear together, after
// the item has passed through the input register and then the result
// register. The receiver cannot stall the block, so each result must be
// captured in the single cycle that valid_o marks it. Opcodes 5 to 7 give a
// result of zero; 16-bit results sit in the low half of result_o.
module float_format_converter (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [ffc_pkg::OpW-1:0]  op_i,
  input  wire logic [ffc_pkg::SrcW-1:0] operand_i,
  output logic                          valid_o,
  output logic      [ffc_pkg::ResW-1:0] result_o
);
  import ffc_pkg::*;

  logic            in_vld_q;
  logic [OpW-1:0]  op_q;
  logic [SrcW-1:0] opnd_q;
  logic            out_vld_q;
  logic [ResW-1:0] res_q, res_d;
  logic [15:0]     nar;
  logic [31:0]     wid;
  logic [31:0]     bf;
  logic [15:0]     h;
  logic [4:0]      hexp;
  logic [9:0]      hsig;
  logic [3:0]      lz;
  logic [9:0]      nsig;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    op_q   <= op_i;
    opnd_q <= operand_i;
    res_q  <= res_d;
  end

  ffc_narrow u_narrow (
    .operand_i (opnd_q),
    .src_dbl_i (op_q == OP_D2H || op_q == OP_D2BF),
    .dst_bf_i  (op_q == OP_D2BF),
    .result_o  (nar)
  );

  // Half to single widening; subnormals are normalised by a short leading-one search.
  always_comb begin
    h    = opnd_q[15:0];
    hexp = h[14:10];
    hsig = h[9:0];
    lz   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hsig[i]) lz = 4'(9 - i);
    end
    nsig = 10'(hsig << (lz + 4'd1));
    if (hexp == 5'h1f) begin
      wid = {h[15], 8'hff, hsig, 13'b0};
    end else if (hexp == 5'd0) begin
      wid = (hsig == '0) ? {h[15], 31'b0}
                         : {h[15], 8'(8'd112 - {4'b0, lz}), nsig, 13'b0};
    end else begin
      wid = {h[15], 8'({3'b0, hexp} + 8'd112), hsig, 13'b0};
    end
  end

  // Single to bfloat16 by the short rounding add.
  always_comb begin
    if (opnd_q[30:0] > 31'h7f800000) begin
      bf = {16'b0, opnd_q[31:16] | 16'h0040};
    end else begin
      bf = opnd_q[31:0] + 32'h7fff + {31'b0, opnd_q[16]};
      bf = {16'b0, bf[31:16]};
    end
  end

  always_comb begin
    unique case (op_q)
      OP_H2S:                  res_d = wid;
      OP_S2H, OP_D2H, OP_D2BF: res_d = {16'b0, nar};
      OP_S2BF:                 res_d = bf;
      default:                 res_d = '0;
    endcase
  end

  assign valid_o  = out_vld_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// ----- design/ffc_checker.sv -----
`default_nettype none
module ffc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic [2:0]  op_i,
  input wire logic        valid_o,
  input wire logic [31:0] result_o
);
  import ffc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##1 valid_o) else $error("result missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> ##1 !valid_o) else $error("spurious result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && op_i != OP_H2S) |=> ##1 result_o[31:16] == 16'h0)
    else $error("upper half not zero");
endmodule

bind float_format_converter ffc_checker u_ffc_checker (.*);
`default_nettype wire

// ----- verif/float_format_converter_tb.sv -----
`default_nettype none
module float_format_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [OpW-1:0]    op = '0;
  logic [SrcW-1:0]   operand = '0;
  wire               busy;
  wire               valid;
  wire  [ResW-1:0]   result;

  logic [ResW-1:0]   pending_results[$];
  int unsigned       fail_count = 0;
  int unsigned       quiet_cycles = 0;
  bit                idling_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  float_format_converter DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start_i  (start),
    .busy_o   (busy),
    .op_i     (op),
    .operand_i(operand),
    .valid_o  (valid),
    .result_o (result)
  );

  // Half to single widening is exact. Subnormal halves are normalised by
  // finding the leading one, and a NaN payload is shifted up without being
  // quietened, so a signalling NaN stays signalling.
  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [31:0] mag;
    logic [9:0]  frac;
    int          lead;
    frac = h[9:0];
    lead = 0;
    if (h[14:10] == 5'h1f) begin
      mag = {1'b0, 8'hff, frac, 13'd0};
    end else if (h[14:10] == 5'd0) begin
      if (frac == 10'd0) begin
        mag = '0;
      end else begin
        for (int i = 0; i < 10; i++) if (frac[i]) lead = i;
        mag = {1'b0, 8'(lead + 103), 23'((32'(frac) << (23 - lead)) & 32'h7fffff)};
      end
    end else begin
      mag = {1'b0, 8'(h[14:10] + 112), frac, 13'd0};
    end
    return {h[15], 31'd0} | mag;
  endfunction

  // Generic narrowing to a 16-bit format with round to nearest even. The
  // source is described by its total width and fraction width, the
  // destination by its fraction width; all arithmetic is done in 64 bits.
  function automatic logic [15:0] narrow_to_16(logic [63:0] a, int src_bits,
                                               int src_frac, int dst_frac);
    int          src_exp_bits, dst_exp_bits, drop;
    logic [63:0] src_inf_exp, src_bias, hidden, frac_mask, src_inf, sign_bit;
    logic [63:0] round_mask, halfway, payload_mask, dst_inf_exp, dst_bias;
    logic [63:0] lower, upper, mag, sgn, v, rb, sh, sig, sticky, den;
    logic [31:0] quiet_bit, r;
    src_exp_bits = src_bits - src_frac - 1;
    dst_exp_bits = 16 - dst_frac - 1;
    drop         = src_frac - dst_frac;
    src_inf_exp  = (64'd1 << src_exp_bits) - 1;
    src_bias     = src_inf_exp >> 1;
    hidden       = 64'd1 << src_frac;
    frac_mask    = hidden - 1;
    src_inf      = src_inf_exp << src_frac;
    sign_bit     = 64'd1 << (src_frac + src_exp_bits);
    round_mask   = (64'd1 << drop) - 1;
    halfway      = 64'd1 << (drop - 1);
    payload_mask = (64'd1 << (src_frac - 1)) - 1;
    dst_inf_exp  = (64'd1 << dst_exp_bits) - 1;
    dst_bias     = dst_inf_exp >> 1;
    lower        = (src_bias + 1 - dst_bias) << src_frac;
    upper        = (src_bias + 1 + dst_bias) << src_frac;
    quiet_bit    = 32'd1 << (dst_frac - 1);
    mag          = a & (sign_bit - 1);
    sgn          = a & sign_bit;
    if (mag >= lower && mag < upper) begin
      v  = (mag >> drop) - ((src_bias - dst_bias) << dst_frac);
      rb = mag & round_mask;
      if (rb > halfway) v++;
      else if (rb == halfway) v += v & 64'd1;
      r = v[31:0];
    end else if (mag > src_inf) begin
      r = (dst_inf_exp[31:0] << dst_frac) | quiet_bit |
          32'(((mag & payload_mask) >> drop) & 64'(quiet_bit - 1));
    end else if (mag >= upper) begin
      r = dst_inf_exp[31:0] << dst_frac;
    end else begin
      // Below the normal range: denormalise with a sticky bit, or flush.
      sh = src_bias - dst_bias - (mag >> src_frac) + 1;
      if (sh > 64'(src_frac)) begin
        r = '0;
      end else begin
        sig    = (a & frac_mask) | hidden;
        sticky = 64'((sig & ((64'd1 << sh) - 1)) != 0);
        den    = (sig >> sh) | sticky;
        v      = den >> drop;
        rb     = den & round_mask;
        if (rb > halfway) v++;
        else if (rb == halfway) v += v & 64'd1;
        r = v[31:0];
      end
    end
    r |= 32'(sgn >> (src_bits - 16));
    return r[15:0];
  endfunction

  // Single to bfloat16 uses the short rounding add; NaNs get bit 6 set.
  function automatic logic [15:0] single_to_bfloat(logic [31:0] u);
    if ((u & 32'h7fffffff) > 32'h7f800000) return u[31:16] | 16'h0040;
    u += 32'h7fff + 32'(u[16]);
    return u[31:16];
  endfunction

  function automatic logic [31:0] converted_value(logic [2:0] code, logic [63:0] x);
    case (code)
      OP_H2S:  return half_to_single(x[15:0]);
      OP_S2H:  return {16'd0, narrow_to_16({32'd0, x[31:0]}, 32, 23, 10)};
      OP_D2H:  return {16'd0, narrow_to_16(x, 64, 52, 10)};
      OP_S2BF: return {16'd0, single_to_bfloat(x[31:0])};
      OP_D2BF: return {16'd0, narrow_to_16(x, 64, 52, 7)};
      default: return '0;
    endcase
  endfunction

  // Sends one item, optionally after a random burst of idle cycles, and
  // records the expected result once the item has been accepted. start is
  // left high so that the next item can follow straight away.
  task automatic send_item(logic [2:0] code, logic [63:0] x);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    op      <= code;
    operand <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(converted_value(code, x));
  endtask

  // Waits until every expected result has arrived; the sender holds off.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // A random value with a chosen exponent field, to aim at one region of a
  // format: the exponent sits at bit position pos with the given width.
  function automatic logic [63:0] shaped_operand(int pos, int width, int unsigned ex);
    logic [63:0] x, exmask;
    x      = {$urandom, $urandom};
    exmask = ((64'd1 << width) - 1) << pos;
    return (x & ~exmask) | ((64'(ex) << pos) & exmask);
  endfunction

  task automatic test_directed();
    // Signed zeros, infinities, NaNs and subnormals of half when widening,
    // including a signalling NaN that must stay signalling.
    send_item(OP_H2S, 64'h0000);
    send_item(OP_H2S, 64'hffff_ffff_ffff_8000);
    send_item(OP_H2S, 64'h7c00);
    send_item(OP_H2S, 64'h7d55);
    send_item(OP_H2S, 64'h0001);
    send_item(OP_H2S, 64'h83ff);
    send_item(OP_H2S, 64'h7bff);
    // Narrowing: overflow, largest finite, halfway ties, subnormal results,
    // flush of a subnormal source and NaN payload keeping.
    send_item(OP_S2H, 64'hffff_ffff_477f_f000);
    send_item(OP_S2H, 64'h4780_0000);
    send_item(OP_S2H, 64'h3f80_1000);
    send_item(OP_S2H, 64'h3380_0001);
    send_item(OP_S2H, 64'h0000_0001);
    send_item(OP_S2H, 64'hff80_0001);
    send_item(OP_D2H, 64'h7ff0_0000_0000_0001);
    send_item(OP_D2H, 64'h8000_0000_0000_0001);
    send_item(OP_D2H, 64'h3e70_0000_0000_0000);
    send_item(OP_D2H, 64'hffff_ffff_ffff_ffff);
    send_item(OP_S2BF, 64'h3f80_8000);
    send_item(OP_S2BF, 64'h7f80_0001);
    send_item(OP_S2BF, 64'h7f7f_ffff);
    send_item(OP_D2BF, 64'h7fef_ffff_ffff_ffff);
    send_item(OP_D2BF, 64'h3810_0000_0000_0000);
    send_item(OP_D2BF, 64'h7ff8_0000_0000_0000);
    // Undefined opcodes give zero.
    send_item(OP_UNDEF_LO, 64'hffff_ffff_ffff_ffff);
    send_item(OP_UNDEF_HI, 64'h1234_5678_9abc_def0);
  endtask

  // Random items, mostly aimed at the exponent region near each boundary of
  // the chosen conversion, with a share of fully random operands.
  task automatic test_random(int unsigned count);
    logic [2:0]  code;
    logic [63:0] x;
    for (int unsigned n = 0; n < count; n++) begin
      code = (($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4)));
      x = {$urandom, $urandom};
      if ($urandom_range(0, 4) != 0) begin
        case (code)
          OP_H2S:  x = shaped_operand(10, 5,
                         ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1) * 31
                                                     : $urandom_range(0, 31));
          OP_S2H, OP_S2BF:
                   x = shaped_operand(23, 8, ($urandom_range(0, 5) == 0) ? 255
                                             : $urandom_range(96, 145));
          default: x = shaped_operand(52, 11, ($urandom_range(0, 5) == 0) ? 2047
                                             : $urandom_range(880, 1170));
        endcase
      end
      send_item(code, x);
      if (n == count / 2) drain_results();
    end
  endtask

  // Back-to-back items with no idling at all.
  task automatic test_streaming(int unsigned count);
    idling_on = 1'b0;
    for (int unsigned n = 0; n < count; n++)
      send_item(3'($urandom_range(0, 7)), {$urandom, $urandom});
  endtask

  // Results are checked as they appear; the receiver cannot stall the block.
  always @(posedge clk) begin
    logic [ResW-1:0] want;
    if (rst_n && valid) begin
      if (pending_results.size() == 0) begin
        $error("result: unexpected item, actual %h", result);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result !== want) begin
          $error("result: expected %h, actual %h", want, result);
          fail_count++;
        end
      end
    end
  end

  // The watchdog counts cycles with neither an accepted item nor a result.
  always @(posedge clk) begin
    if ((start && !busy) || valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("float_format_converter_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_results();
    test_random(470);
    test_streaming(60);
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("float_format_converter_tb OK");
    end else begin
      $display("float_format_converter_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
